// ===== rtl/hslrgb_pkg.sv =====
// Shared constants, types and helpers for the HSL to RGB color pipeline.
package hslrgb_pkg;

  localparam int HUE_BITS        = 16;
  localparam int LEVEL_FRAC_BITS = 8;

  localparam int LEVEL_W  = LEVEL_FRAC_BITS + 1;
  localparam int MQ_W     = 2 * LEVEL_FRAC_BITS + 1;
  localparam int SUM_W    = MQ_W + 1;
  localparam int FAC_W    = HUE_BITS + 1;
  localparam int VAL_W    = 2 * LEVEL_FRAC_BITS + HUE_BITS + 1;
  localparam int PROD_W   = MQ_W + FAC_W;
  localparam int HX6_W    = HUE_BITS + 3;
  localparam int CHAN_W   = 8;
  localparam int SCALE_W  = VAL_W + CHAN_W;
  localparam int PIPE_DEPTH = 5;

  localparam logic [LEVEL_W-1:0]  LEVEL_ONE  = LEVEL_W'(1) << LEVEL_FRAC_BITS;
  localparam logic [LEVEL_W-1:0]  LEVEL_HALF = LEVEL_W'(1) << (LEVEL_FRAC_BITS - 1);
  localparam logic [MQ_W-1:0]     MQ_ONE     = MQ_W'(1) << (2 * LEVEL_FRAC_BITS);
  localparam logic [HUE_BITS-1:0] HUE_THIRD  = HUE_BITS'((64'd1 << HUE_BITS) / 3);
  localparam logic [CHAN_W-1:0]   CHAN_MAX   = '1;
  localparam logic [CHAN_W-1:0]   ALPHA      = 8'hff;

  typedef enum logic [1:0] {
    SEG_RISE,
    SEG_HIGH,
    SEG_FALL,
    SEG_LOW
  } ramp_seg_t;

  typedef struct packed {
    logic [MQ_W-1:0] m1;
    logic [MQ_W-1:0] m2;
  } level_t;

  function automatic logic [LEVEL_W-1:0] clamp_level(input logic [LEVEL_W-1:0] v);
    return (v > LEVEL_ONE) ? LEVEL_ONE : v;
  endfunction

endpackage

// ===== rtl/hslrgb_level.sv =====
// Two-stage computation of the ramp limits m1 and m2 from saturation and lightness.
module hslrgb_level (
  input  logic                             clk,
  input  logic [hslrgb_pkg::LEVEL_W-1:0]   saturation,
  input  logic [hslrgb_pkg::LEVEL_W-1:0]   lightness,
  output hslrgb_pkg::level_t               lev
);
  import hslrgb_pkg::*;

  logic [LEVEL_W-1:0] sc;
  logic [LEVEL_W-1:0] lc;
  logic [MQ_W-1:0]    ls;
  logic               low;
  logic [SUM_W-1:0]   m2_wide;
  logic [SUM_W-1:0]   m1_wide;
  logic [SUM_W-1:0]   l_scaled;
  logic [SUM_W-1:0]   ls_wide;

  always_ff @(posedge clk) begin
    sc  <= clamp_level(saturation);
    lc  <= clamp_level(lightness);
    ls  <= MQ_W'(clamp_level(saturation)) * MQ_W'(clamp_level(lightness));
    low <= clamp_level(lightness) < LEVEL_HALF;
  end

  always_comb begin
    l_scaled = SUM_W'(lc) << LEVEL_FRAC_BITS;
    ls_wide  = SUM_W'(ls);
    if (low) begin
      m2_wide = l_scaled + ls_wide;
    end else begin
      m2_wide = ((SUM_W'(lc) + SUM_W'(sc)) << LEVEL_FRAC_BITS) - ls_wide;
    end
    m1_wide = (l_scaled << 1) - m2_wide;
  end

  always_ff @(posedge clk) begin
    lev.m1 <= m1_wide[MQ_W-1:0];
    lev.m2 <= m2_wide[MQ_W-1:0];
  end

endmodule

// ===== rtl/hslrgb_ramp.sv =====
// Pipelined hue ramp evaluation and 8-bit scaling for one color channel.
module hslrgb_ramp (
  input  logic                             clk,
  input  logic [hslrgb_pkg::HUE_BITS-1:0]  hx,
  input  hslrgb_pkg::level_t               lev,
  output logic [hslrgb_pkg::CHAN_W-1:0]    chan
);
  import hslrgb_pkg::*;

  localparam logic [HX6_W-1:0] TURN   = HX6_W'(1) << HUE_BITS;
  localparam logic [HX6_W-1:0] TURN2  = HX6_W'(2) << HUE_BITS;
  localparam logic [HX6_W-1:0] TURN4  = HX6_W'(4) << HUE_BITS;

  logic [HUE_BITS-1:0] hx_a;
  logic [HX6_W-1:0]    six;
  logic [HX6_W-1:0]    three;
  logic [HX6_W-1:0]    fall;
  ramp_seg_t           seg_next;
  logic [FAC_W-1:0]    fac_next;
  ramp_seg_t           seg_b;
  logic [FAC_W-1:0]    fac_b;
  logic [MQ_W-1:0]     span;
  logic [PROD_W-1:0]   prod_full;
  logic [VAL_W-1:0]    prod_c;
  logic [MQ_W-1:0]     m1_c;
  logic [MQ_W-1:0]     m2_c;
  ramp_seg_t           seg_c;
  logic [VAL_W-1:0]    v_next;
  logic [VAL_W-1:0]    v_d;
  logic [SCALE_W-1:0]  scaled;
  logic [CHAN_W:0]     c_raw;

  always_ff @(posedge clk) begin
    hx_a <= hx;
  end

  always_comb begin
    six   = HX6_W'(hx_a) * HX6_W'(6);
    three = HX6_W'(hx_a) * HX6_W'(3);
    fall  = TURN4 - six;
    if (six < TURN) begin
      seg_next = SEG_RISE;
      fac_next = six[FAC_W-1:0];
    end else if (!hx_a[HUE_BITS-1]) begin
      seg_next = SEG_HIGH;
      fac_next = '0;
    end else if (three < TURN2) begin
      seg_next = SEG_FALL;
      fac_next = fall[FAC_W-1:0];
    end else begin
      seg_next = SEG_LOW;
      fac_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    seg_b <= seg_next;
    fac_b <= fac_next;
  end

  assign span      = lev.m2 - lev.m1;
  assign prod_full = PROD_W'(span) * PROD_W'(fac_b);

  always_ff @(posedge clk) begin
    prod_c <= prod_full[VAL_W-1:0];
    m1_c   <= lev.m1;
    m2_c   <= lev.m2;
    seg_c  <= seg_b;
  end

  always_comb begin
    unique case (seg_c) inside
      SEG_RISE, SEG_FALL: v_next = ({m1_c, {HUE_BITS{1'b0}}}) + prod_c;
      SEG_HIGH:           v_next = {m2_c, {HUE_BITS{1'b0}}};
      SEG_LOW:            v_next = {m1_c, {HUE_BITS{1'b0}}};
      default:            v_next = {m1_c, {HUE_BITS{1'b0}}};
    endcase
  end

  always_ff @(posedge clk) begin
    v_d <= v_next;
  end

  assign scaled = {v_d, {CHAN_W{1'b0}}} - SCALE_W'(v_d);
  assign c_raw  = scaled[SCALE_W-1:VAL_W-1];

  always_ff @(posedge clk) begin
    chan <= c_raw[CHAN_W] ? CHAN_MAX : c_raw[CHAN_W-1:0];
  end

endmodule

// ===== rtl/hsl_to_rgb_color_pack.sv =====
// Top level of the HSL to RGB color conversion pipeline with packed output.
//
//  channel   signals                                   direction  handshake
//  command   start, busy, hue, saturation, lightness   in         start && !busy
//  result    done, red, green, blue, packed_color      out        done, one cycle
//
//  The start transfer reaches done through the five register stages of the
//  ramp path: hue register, segment select, span multiply, ramp sum and 255x
//  scaling. The pipeline accepts one item per cycle.
//  busy stays low; the pipeline always advances.
//  rst clears the valid bits only; payload registers are not reset.
//  Results are never held: done marks each one for exactly one cycle.
module hsl_to_rgb_color_pack (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [hslrgb_pkg::HUE_BITS-1:0]  hue,
  input  logic [hslrgb_pkg::LEVEL_W-1:0]   saturation,
  input  logic [hslrgb_pkg::LEVEL_W-1:0]   lightness,
  output logic                             done,
  output logic [hslrgb_pkg::CHAN_W-1:0]    red,
  output logic [hslrgb_pkg::CHAN_W-1:0]    green,
  output logic [hslrgb_pkg::CHAN_W-1:0]    blue,
  output logic [31:0]                      packed_color
);
  import hslrgb_pkg::*;

  logic [PIPE_DEPTH-1:0] vld;
  logic [HUE_BITS-1:0]   hue_red;
  logic [HUE_BITS-1:0]   hue_blue;
  level_t                lev;

  assign busy     = 1'b0;
  assign hue_red  = hue + HUE_THIRD;
  assign hue_blue = hue - HUE_THIRD;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[PIPE_DEPTH-2:0], start && !busy};
    end
  end

  hslrgb_level u_level (
    .clk        (clk),
    .saturation (saturation),
    .lightness  (lightness),
    .lev        (lev)
  );

  hslrgb_ramp u_ramp_red (
    .clk  (clk),
    .hx   (hue_red),
    .lev  (lev),
    .chan (red)
  );

  hslrgb_ramp u_ramp_green (
    .clk  (clk),
    .hx   (hue),
    .lev  (lev),
    .chan (green)
  );

  hslrgb_ramp u_ramp_blue (
    .clk  (clk),
    .hx   (hue_blue),
    .lev  (lev),
    .chan (blue)
  );

  assign done         = vld[PIPE_DEPTH-1];
  assign packed_color = {ALPHA, blue, green, red};

  a_done_from_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, PIPE_DEPTH))
    else $error("result strobe without a matching start transfer");

  a_start_to_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##PIPE_DEPTH done)
    else $error("start transfer did not produce a result");

  a_level_order: assert property (@(posedge clk) disable iff (rst)
    vld[1] |-> (lev.m1 <= lev.m2))
    else $error("ramp low limit above high limit");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    vld[1] |-> (lev.m2 <= MQ_ONE))
    else $error("ramp high limit above one");

endmodule
